// ----- rtl/klex_pkg.sv -----
// ----------------------------------------------------------------------------
// klex_pkg
// Shared types, token codes, character codes and keyword tables for the
// keyword lexer.
// ----------------------------------------------------------------------------
package klex_pkg;

    // Token kinds
    localparam logic [5:0] TK_EOF      = 6'd0;
    localparam logic [5:0] TK_ID       = 6'd1;
    localparam logic [5:0] TK_NUMBER   = 6'd2;
    localparam logic [5:0] TK_STRING   = 6'd3;
    localparam logic [5:0] TK_KEYWORD0 = 6'd4;
    localparam logic [5:0] TK_PAIR_EQ  = 6'd17;
    localparam logic [5:0] TK_PAIR_NE  = 6'd18;
    localparam logic [5:0] TK_PAIR_GE  = 6'd19;
    localparam logic [5:0] TK_PAIR_LE  = 6'd20;
    localparam logic [5:0] TK_SEMI     = 6'd21;
    localparam logic [5:0] TK_ASSIGN   = 6'd22;
    localparam logic [5:0] TK_PLUS     = 6'd23;
    localparam logic [5:0] TK_MINUS    = 6'd24;
    localparam logic [5:0] TK_STAR     = 6'd25;
    localparam logic [5:0] TK_SLASH    = 6'd26;
    localparam logic [5:0] TK_LPAREN   = 6'd27;
    localparam logic [5:0] TK_RPAREN   = 6'd28;
    localparam logic [5:0] TK_LBRACE   = 6'd29;
    localparam logic [5:0] TK_RBRACE   = 6'd30;
    localparam logic [5:0] TK_LESS     = 6'd31;
    localparam logic [5:0] TK_GREATER  = 6'd32;
    localparam logic [5:0] TK_COMMA    = 6'd33;
    localparam logic [5:0] TK_ERROR    = 6'd34;
    localparam logic [5:0] TK_NONE     = 6'd0;

    // Input item kinds
    localparam logic IN_BYTE = 1'b0;
    localparam logic IN_END  = 1'b1;

    // Character codes
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    localparam logic [15:0] SAT16 = 16'hFFFF;

    // Keyword table: text right aligned in 64 bits, plus length
    localparam int NUM_KW = 13;
    localparam logic [63:0] KW_TEXT [NUM_KW] = '{
        64'("var"), 64'("print"), 64'("if"), 64'("while"), 64'("break"),
        64'("continue"), 64'("fn"), 64'("return"), 64'("true"),
        64'("false"), 64'("not"), 64'("and"), 64'("or")
    };
    localparam logic [3:0] KW_LEN [NUM_KW] = '{
        4'd3, 4'd5, 4'd2, 4'd5, 4'd5, 4'd8, 4'd2, 4'd6, 4'd4, 4'd5, 4'd3, 4'd3, 4'd2
    };

    // One result item
    typedef struct packed {
        logic [5:0]  token_kind;
        logic [15:0] start_line;
        logic [15:0] start_column;
        logic [15:0] token_length;
        logic        last;
    } tok_t;

    // Results of one input item on their way to the output queue
    typedef struct packed {
        logic [1:0] count;
        tok_t       tok1;
        tok_t       tok0;
    } push_t;

    function automatic logic [15:0] sat_inc(input logic [15:0] v);
        return (v != SAT16) ? v + 16'd1 : SAT16;
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == CH_UNDER;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    // Character idx of keyword k (idx below the keyword length)
    function automatic logic [7:0] kw_char(input int k, input logic [2:0] idx);
        logic [63:0] w;
        logic [3:0]  sh;
        w  = KW_TEXT[k];
        sh = KW_LEN[k] - 4'd1 - {1'b0, idx};
        w  = w >> {sh[2:0], 3'b000};
        return w[7:0];
    endfunction

    function automatic logic [5:0] single_kind(input logic [7:0] c);
        logic [5:0] r;
        case (c)
            CH_SEMI:   r = TK_SEMI;
            CH_EQ:     r = TK_ASSIGN;
            CH_PLUS:   r = TK_PLUS;
            CH_MINUS:  r = TK_MINUS;
            CH_STAR:   r = TK_STAR;
            CH_SLASH:  r = TK_SLASH;
            CH_LPAREN: r = TK_LPAREN;
            CH_RPAREN: r = TK_RPAREN;
            CH_LBRACE: r = TK_LBRACE;
            CH_RBRACE: r = TK_RBRACE;
            CH_LT:     r = TK_LESS;
            CH_GT:     r = TK_GREATER;
            CH_COMMA:  r = TK_COMMA;
            default:   r = TK_NONE;
        endcase
        return r;
    endfunction

    function automatic logic [5:0] pair_kind(input logic [7:0] h);
        logic [5:0] r;
        case (h)
            CH_EQ:   r = TK_PAIR_EQ;
            CH_BANG: r = TK_PAIR_NE;
            CH_GT:   r = TK_PAIR_GE;
            default: r = TK_PAIR_LE;
        endcase
        return r;
    endfunction

    function automatic tok_t make_tok(input logic [5:0] k, input logic [15:0] ln,
                                      input logic [15:0] col, input logic [15:0] len);
        tok_t t;
        t.token_kind   = k;
        t.start_line   = ln;
        t.start_column = col;
        t.token_length = len;
        t.last         = 1'b0;
        return t;
    endfunction

endpackage

// ----- rtl/klex_if.sv -----
// ----------------------------------------------------------------------------
// klex_if
// Valid/ready channels of the keyword lexer: text input and token output.
// ----------------------------------------------------------------------------
interface klex_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] text_byte;

    modport source (output valid, output kind, output text_byte, input ready);
    modport sink   (input valid, input kind, input text_byte, output ready);
endinterface

interface klex_out_if;
    logic        valid;
    logic        ready;
    logic [5:0]  token_kind;
    logic [15:0] start_line;
    logic [15:0] start_column;
    logic [15:0] token_length;
    logic        last;

    modport source (output valid, output token_kind, output start_line,
                    output start_column, output token_length, output last,
                    input ready);
    modport sink   (input valid, input token_kind, input start_line,
                    input start_column, input token_length, input last,
                    output ready);
endinterface

// ----- rtl/klex_core.sv -----
// ----------------------------------------------------------------------------
// klex_core
// Scanner state and per-byte next-state logic; produces up to two tokens
// for every accepted input item.
// ----------------------------------------------------------------------------
module klex_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic               kind,
    input  logic [7:0]         text_byte,
    output klex_pkg::push_t    push
);
    import klex_pkg::*;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_IDENT,
        MODE_NUMBER,
        MODE_STRING,
        MODE_HELD,
        MODE_ERROR
    } mode_t;

    mode_t       mode_reg,       mode_next;
    logic [7:0]  held_reg,       held_next;
    logic [12:0] cand_reg,       cand_next;
    logic        after_bs_reg,   after_bs_next;
    logic [15:0] tok_line_reg,   tok_line_next;
    logic [15:0] tok_col_reg,    tok_col_next;
    logic [15:0] count_reg,      count_next;
    logic [15:0] cur_line_reg,   cur_line_next;
    logic [15:0] cur_col_reg,    cur_col_next;

    tok_t        res [2];
    logic [1:0]  n;
    logic        do_start;
    logic [12:0] cand_upd;
    logic [12:0] cand_first;
    logic [5:0]  ident_kind;
    logic        c_alpha;
    logic        c_digit;
    logic [5:0]  c_single;

    // Keyword candidate filtering and final keyword lookup
    always_comb
    begin
        cand_upd   = cand_reg;
        cand_first = '0;
        ident_kind = TK_ID;
        for (int k = 0; k < NUM_KW; k++)
        begin
            if (!(count_reg < 16'(KW_LEN[k]) && kw_char(k, count_reg[2:0]) == text_byte))
            begin
                cand_upd[k] = 1'b0;
            end
            cand_first[k] = (kw_char(k, 3'd0) == text_byte);
            if (cand_reg[k] && count_reg == 16'(KW_LEN[k]))
            begin
                ident_kind = TK_KEYWORD0 + 6'(k);
            end
        end
    end

    assign c_alpha  = is_alpha(text_byte);
    assign c_digit  = is_digit(text_byte);
    assign c_single = single_kind(text_byte);

    // Next state and results of one input item
    always_comb
    begin
        mode_next     = mode_reg;
        held_next     = held_reg;
        cand_next     = cand_reg;
        after_bs_next = after_bs_reg;
        tok_line_next = tok_line_reg;
        tok_col_next  = tok_col_reg;
        count_next    = count_reg;
        cur_line_next = cur_line_reg;
        cur_col_next  = cur_col_reg;
        res[0]        = '0;
        res[1]        = '0;
        n             = 2'd0;
        do_start      = 1'b0;

        if (accept && kind == IN_END)
        begin
            // Flush the token in progress, then eof and back to reset state
            case (mode_reg)
                MODE_IDENT:
                begin
                    res[0] = make_tok(ident_kind, tok_line_reg, tok_col_reg, count_reg);
                    n = 2'd1;
                end
                MODE_NUMBER:
                begin
                    res[0] = make_tok(TK_NUMBER, tok_line_reg, tok_col_reg, count_reg);
                    n = 2'd1;
                end
                MODE_STRING:
                begin
                    res[0] = make_tok(TK_STRING, tok_line_reg, tok_col_reg, count_reg);
                    n = 2'd1;
                end
                MODE_HELD:
                begin
                    res[0] = make_tok((held_reg == CH_BANG) ? TK_ERROR : single_kind(held_reg),
                                      tok_line_reg, tok_col_reg, 16'd1);
                    n = 2'd1;
                end
                default:
                begin
                    n = 2'd0;
                end
            endcase
            res[n[0]] = make_tok(TK_EOF, cur_line_reg, cur_col_reg, 16'd0);
            n = n + 2'd1;
            mode_next     = MODE_IDLE;
            held_next     = '0;
            cand_next     = '1;
            after_bs_next = 1'b0;
            tok_line_next = 16'd1;
            tok_col_next  = 16'd1;
            count_next    = '0;
            cur_line_next = 16'd1;
            cur_col_next  = 16'd1;
        end
        else if (accept)
        begin
            case (mode_reg)
                MODE_IDENT:
                begin
                    if (c_alpha || c_digit)
                    begin
                        cand_next    = cand_upd;
                        count_next   = sat_inc(count_reg);
                        cur_col_next = sat_inc(cur_col_reg);
                    end
                    else
                    begin
                        res[0]   = make_tok(ident_kind, tok_line_reg, tok_col_reg, count_reg);
                        n        = 2'd1;
                        do_start = 1'b1;
                    end
                end
                MODE_NUMBER:
                begin
                    if (c_digit)
                    begin
                        count_next   = sat_inc(count_reg);
                        cur_col_next = sat_inc(cur_col_reg);
                    end
                    else
                    begin
                        res[0]   = make_tok(TK_NUMBER, tok_line_reg, tok_col_reg, count_reg);
                        n        = 2'd1;
                        do_start = 1'b1;
                    end
                end
                MODE_STRING:
                begin
                    cur_col_next = sat_inc(cur_col_reg);
                    if (text_byte == CH_QUOTE && !after_bs_reg)
                    begin
                        res[0]        = make_tok(TK_STRING, tok_line_reg, tok_col_reg, count_reg);
                        n             = 2'd1;
                        mode_next     = MODE_IDLE;
                        after_bs_next = 1'b0;
                    end
                    else
                    begin
                        count_next    = sat_inc(count_reg);
                        after_bs_next = (text_byte == CH_BSLASH);
                    end
                end
                MODE_HELD:
                begin
                    held_next = '0;
                    n         = 2'd1;
                    if (text_byte == CH_EQ)
                    begin
                        res[0]       = make_tok(pair_kind(held_reg), tok_line_reg,
                                                tok_col_reg, 16'd2);
                        mode_next    = MODE_IDLE;
                        cur_col_next = sat_inc(cur_col_reg);
                    end
                    else if (held_reg == CH_BANG)
                    begin
                        // lone '!': error, the following byte is dropped
                        res[0]    = make_tok(TK_ERROR, tok_line_reg, tok_col_reg, 16'd1);
                        mode_next = MODE_ERROR;
                    end
                    else
                    begin
                        res[0]   = make_tok(single_kind(held_reg), tok_line_reg,
                                            tok_col_reg, 16'd1);
                        do_start = 1'b1;
                    end
                end
                MODE_IDLE:
                begin
                    do_start = 1'b1;
                end
                default:
                begin
                    // error mode: byte dropped, counters frozen
                    n = 2'd0;
                end
            endcase

            // Byte arriving between tokens
            if (do_start)
            begin
                mode_next     = MODE_IDLE;
                tok_line_next = cur_line_reg;
                tok_col_next  = cur_col_reg;
                cur_col_next  = sat_inc(cur_col_reg);
                if (text_byte == CH_SPACE || text_byte == CH_TAB)
                begin
                    cur_col_next = sat_inc(cur_col_reg);
                end
                else if (text_byte == CH_CR)
                begin
                    cur_col_next = cur_col_reg;
                end
                else if (text_byte == CH_NL)
                begin
                    cur_line_next = sat_inc(cur_line_reg);
                    cur_col_next  = 16'd1;
                end
                else if (c_alpha)
                begin
                    cand_next  = cand_first;
                    count_next = 16'd1;
                    mode_next  = MODE_IDENT;
                end
                else if (c_digit)
                begin
                    count_next = 16'd1;
                    mode_next  = MODE_NUMBER;
                end
                else if (text_byte == CH_QUOTE)
                begin
                    count_next    = '0;
                    after_bs_next = 1'b0;
                    mode_next     = MODE_STRING;
                end
                else if (text_byte == CH_EQ || text_byte == CH_LT ||
                         text_byte == CH_GT || text_byte == CH_BANG)
                begin
                    held_next = text_byte;
                    mode_next = MODE_HELD;
                end
                else if (c_single != TK_NONE)
                begin
                    res[n[0]] = make_tok(c_single, cur_line_reg, cur_col_reg, 16'd1);
                    n = n + 2'd1;
                end
                else
                begin
                    res[n[0]] = make_tok(TK_ERROR, cur_line_reg, cur_col_reg, 16'd1);
                    n = n + 2'd1;
                    mode_next = MODE_ERROR;
                end
            end
        end

        // Mark the final result of this item
        if (n == 2'd2)
        begin
            res[1].last = 1'b1;
        end
        else if (n == 2'd1)
        begin
            res[0].last = 1'b1;
        end
    end

    assign push.count = n;
    assign push.tok0  = res[0];
    assign push.tok1  = res[1];

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_IDLE;
            held_reg     <= '0;
            cand_reg     <= '1;
            after_bs_reg <= 1'b0;
            tok_line_reg <= 16'd1;
            tok_col_reg  <= 16'd1;
            count_reg    <= '0;
            cur_line_reg <= 16'd1;
            cur_col_reg  <= 16'd1;
        end
        else
        begin
            mode_reg     <= mode_next;
            held_reg     <= held_next;
            cand_reg     <= cand_next;
            after_bs_reg <= after_bs_next;
            tok_line_reg <= tok_line_next;
            tok_col_reg  <= tok_col_next;
            count_reg    <= count_next;
            cur_line_reg <= cur_line_next;
            cur_col_reg  <= cur_col_next;
        end
    end

endmodule

// ----- rtl/klex_tok_queue.sv -----
// ----------------------------------------------------------------------------
// klex_tok_queue
// Four-entry token queue: takes up to two tokens per cycle, presents one
// per cycle on the output channel while tok_out.ready is high.
// ----------------------------------------------------------------------------
module klex_tok_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  klex_pkg::push_t  push,
    output logic             has_room,
    klex_out_if.source       tok_out
);
    import klex_pkg::*;

    tok_t       mem_reg [4];
    logic [1:0] wr_ptr_reg, wr_ptr_next;
    logic [1:0] rd_ptr_reg, rd_ptr_next;
    logic [2:0] fill_reg,   fill_next;
    logic       pop;
    tok_t       head;

    // Room for the worst case of two tokens from the next item
    assign has_room = (fill_reg <= 3'd2);

    assign pop  = tok_out.valid && tok_out.ready;
    assign head = mem_reg[rd_ptr_reg];

    assign tok_out.valid        = (fill_reg != 3'd0);
    assign tok_out.token_kind   = head.token_kind;
    assign tok_out.start_line   = head.start_line;
    assign tok_out.start_column = head.start_column;
    assign tok_out.token_length = head.token_length;
    assign tok_out.last         = head.last;

    // Pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + push.count;
        rd_ptr_next = rd_ptr_reg + {1'b0, pop};
        fill_next   = fill_reg + {1'b0, push.count} - {2'b00, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Token storage
    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= push.tok0;
        end
        if (push.count == 2'd2)
        begin
            mem_reg[wr_ptr_reg + 2'd1] <= push.tok1;
        end
    end

endmodule

// ----- rtl/keyword_lexer.sv -----
// ----------------------------------------------------------------------------
// keyword_lexer
// Byte-serial lexer: source text in, tokens with kind and position out.
// ----------------------------------------------------------------------------
// Usage:
//   text_in carries one item per transfer: a text byte (kind 0) or the end
//   of text mark (kind 1). tok_out carries tokens: kind, start line, start
//   column, length, and last on the final token caused by one input item.
//   An input item causes zero, one or two tokens; the end mark always
//   causes eof and restarts the scanner for a new text.
// Output: a token is on tok_out in the cycle after the transfer that caused
//   it, when the queue in front of it is empty.
// Throughput: one input item per cycle while items cause at most one token
//   each and tok_out.ready is high; the token queue drains one token per
//   cycle, so items causing two tokens fill it. The four-entry queue sets
//   the figure: text_in.ready is high while it holds two tokens or fewer.
// Stalls: when the receiver holds tok_out.ready low, tokens wait in the
//   queue and text_in.ready falls once the queue cannot take two more.
// Reset: rst_n clears the scanner to line 1, column 1 and empties the queue.
// ----------------------------------------------------------------------------
module keyword_lexer (
    input  logic       clk,
    input  logic       rst_n,
    klex_in_if.sink    text_in,
    klex_out_if.source tok_out
);
    import klex_pkg::*;

    push_t push;
    logic  has_room;
    logic  accept;

    // Input transfer
    assign text_in.ready = has_room;
    assign accept        = text_in.valid && has_room;

    klex_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .kind      (text_in.kind),
        .text_byte (text_in.text_byte),
        .push      (push)
    );

    klex_tok_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .has_room (has_room),
        .tok_out  (tok_out)
    );

endmodule
